### sv/mjp_pkg.sv
package mjp_pkg;

  localparam int unsigned DUR_W = 16;
  localparam int unsigned POS_W = 32;
  localparam logic [DUR_W-1:0] DUR_RESET = 16'd1;

  typedef struct packed {
    logic [DUR_W-1:0]        elapsed_ticks;
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic signed [POS_W-1:0] start_z;
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic signed [POS_W-1:0] goal_z;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    past_end;
  } out_item_t;

endpackage

### sv/min_jerk_position_profile.sv
// Minimum-jerk set-point generator for three axes (x, y, z).
// Input channel in_valid/in_ready/in_data carries elapsed ticks plus start and
// goal positions (signed Q16.16). Output channel out_valid/out_ready/out_data
// gives one item per input: the three profiled positions and past_end.
// cfg_wr_en/cfg_wr_data write move_duration (a zero duration acts as one);
// write it only while no item is in flight.
// Pipeline: the input stage loads at the accepting edge, then FRAC_BITS + 1
// stages of the restoring divider that forms the normalized time, four
// stages of the blend polynomial, one multiply stage in each axis lane and
// the output register. Throughput: one item per cycle while in_ready is
// high; the divider and lanes are fully pipelined.
// A stalled receiver first fills the output register and a one-entry skid
// register; in_ready drops only once the skid entry is full, and it comes
// from a register, not from out_ready.
// Reset clears all valid flags, empties the output and sets move_duration
// to one tick.
module min_jerk_position_profile #(
  parameter int TIME_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [mjp_pkg::DUR_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mjp_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mjp_pkg::out_item_t                out_data
);

  localparam int TW   = (TIME_BITS < mjp_pkg::DUR_W) ? TIME_BITS : mjp_pkg::DUR_W;
  localparam int DS   = FRAC_BITS + 1;
  localparam int DLY  = DS + 4;
  localparam int PIPE = DS + 6;

  logic [mjp_pkg::DUR_W-1:0] move_duration;
  logic                      adv;
  logic                      acc;
  logic [TW-1:0]             t_in;
  logic [TW-1:0]             d_in;
  logic                      past_in;
  logic [TW-1:0]             t0;
  logic [TW-1:0]             d0;
  logic [PIPE-1:0]           vld;
  logic [PIPE-1:0]           pst;
  logic [FRAC_BITS:0]        s_q;
  logic [FRAC_BITS:0]        b_q;
  mjp_pkg::out_item_t        res;
  mjp_pkg::out_item_t        skid;
  logic                      skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_duration <= mjp_pkg::DUR_RESET;
    end else if (cfg_wr_en) begin
      move_duration <= cfg_wr_data;
    end
  end

  assign adv      = !skid_valid;
  assign in_ready = adv;
  assign acc      = in_valid && adv;

  assign t_in    = in_data.elapsed_ticks[TW-1:0];
  assign d_in    = (move_duration[TW-1:0] == '0) ? TW'(1) : move_duration[TW-1:0];
  assign past_in = t_in > d_in;

  // past the end: time clamped to the duration gives a blend of exactly one
  always_ff @(posedge clk) begin
    if (adv) begin
      t0  <= past_in ? d_in : t_in;
      d0  <= d_in;
      pst <= {pst[PIPE-2:0], past_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE-2:0], acc};
    end
  end

  mjp_div #(.TW(TW), .FB(FRAC_BITS)) u_div (
    .clk (clk),
    .adv (adv),
    .t   (t0),
    .d   (d0),
    .quo (s_q)
  );

  mjp_blend #(.FB(FRAC_BITS)) u_blend (
    .clk (clk),
    .adv (adv),
    .s   (s_q),
    .b   (b_q)
  );

  mjp_lane #(.FB(FRAC_BITS), .DLY(DLY)) u_lane_x (
    .clk   (clk),
    .adv   (adv),
    .start (in_data.start_x),
    .goal  (in_data.goal_x),
    .b     (b_q),
    .pos   (res.pos_x)
  );

  mjp_lane #(.FB(FRAC_BITS), .DLY(DLY)) u_lane_y (
    .clk   (clk),
    .adv   (adv),
    .start (in_data.start_y),
    .goal  (in_data.goal_y),
    .b     (b_q),
    .pos   (res.pos_y)
  );

  mjp_lane #(.FB(FRAC_BITS), .DLY(DLY)) u_lane_z (
    .clk   (clk),
    .adv   (adv),
    .start (in_data.start_z),
    .goal  (in_data.goal_z),
    .b     (b_q),
    .pos   (res.pos_z)
  );

  assign res.past_end = pst[PIPE-1];

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !out_ready) begin
      if (vld[PIPE-1]) begin
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid <= vld[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid;
      end
    end else if (out_valid && !out_ready) begin
      if (vld[PIPE-1]) begin
        skid <= res;
      end
    end else if (vld[PIPE-1]) begin
      out_data <= res;
    end
  end

endmodule

### sv/mjp_div.sv
module mjp_div #(
  parameter int TW = 16,
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [TW-1:0] t,
  input  logic [TW-1:0] d,
  output logic [FB:0]   quo
);

  localparam int DS = FB + 1;
  localparam int NW = TW + FB + 1;

  logic [NW-1:0] num;
  logic [TW-1:0] rem_r [DS];
  logic [DS-1:0] low_r [DS];
  logic [DS-1:0] quo_r [DS];
  logic [TW-1:0] den_r [DS];

  // rounded numerator t * 2^FB + d/2, quotient known to fit FB+1 bits since t <= d
  assign num = NW'({t, {FB{1'b0}}}) + NW'(d >> 1);

  for (genvar k = 0; k < DS; k++) begin : g_stage
    logic [TW-1:0] prev_rem;
    logic [DS-1:0] prev_low;
    logic [DS-1:0] prev_quo;
    logic [TW-1:0] prev_den;
    logic [TW:0]   cand;
    logic          take;

    if (k == 0) begin : g_first
      assign prev_rem = num[NW-1:FB+1];
      assign prev_low = num[FB:0];
      assign prev_quo = '0;
      assign prev_den = d;
    end else begin : g_rest
      assign prev_rem = rem_r[k-1];
      assign prev_low = low_r[k-1];
      assign prev_quo = quo_r[k-1];
      assign prev_den = den_r[k-1];
    end

    assign cand = {prev_rem, prev_low[DS-1]};
    assign take = cand >= {1'b0, prev_den};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= take ? TW'(cand - {1'b0, prev_den}) : cand[TW-1:0];
        low_r[k] <= prev_low << 1;
        quo_r[k] <= {prev_quo[DS-2:0], take};
        den_r[k] <= prev_den;
      end
    end
  end

  assign quo = quo_r[DS-1];

endmodule

### sv/mjp_blend.sv
module mjp_blend #(
  parameter int FB = 16
) (
  input  logic        clk,
  input  logic        adv,
  input  logic [FB:0] s,
  output logic [FB:0] b
);

  localparam int SQW = 2 * FB + 2;
  localparam int IW  = FB + 5;
  localparam int INW = FB + 4;
  localparam int PW  = 2 * FB + 5;
  localparam logic [SQW-1:0] HALF_S  = SQW'(1) << (FB - 1);
  localparam logic [PW-1:0]  HALF_P  = PW'(1) << (FB - 1);
  localparam logic [IW-1:0]  K6      = IW'(6);
  localparam logic [IW-1:0]  K15     = IW'(15);
  localparam logic [IW-1:0]  TEN_ONE = IW'(10) << FB;
  localparam logic [FB:0]    ONE     = (FB + 1)'(1) << FB;

  logic [SQW-1:0] sq_r;
  logic [FB:0]    s_a;
  logic [SQW-1:0] sq_rnd;
  logic [FB:0]    s2;
  logic [IW-1:0]  i_pos;
  logic [IW-1:0]  i_neg;
  logic [SQW-1:0] p3_r;
  logic [INW-1:0] inner_r;
  logic [SQW-1:0] p3_rnd;
  logic [FB:0]    s3;
  logic [PW-1:0]  prod_r;
  logic [PW-1:0]  prod_rnd;
  logic [PW-FB-1:0] bq;

  // s^2
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= SQW'(s) * SQW'(s);
      s_a  <= s;
    end
  end

  assign sq_rnd = sq_r + HALF_S;
  assign s2     = sq_rnd[2*FB:FB];
  assign i_pos  = IW'(s2) * K6 + TEN_ONE;
  assign i_neg  = IW'(s_a) * K15;

  // s^3 and the inner polynomial 6 s^2 - 15 s + 10
  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r    <= SQW'(s2) * SQW'(s_a);
      inner_r <= (i_pos < i_neg) ? '0 : INW'(i_pos - i_neg);
    end
  end

  assign p3_rnd = p3_r + HALF_S;
  assign s3     = p3_rnd[2*FB:FB];

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PW'(s3) * PW'(inner_r);
    end
  end

  assign prod_rnd = prod_r + HALF_P;
  assign bq       = prod_rnd[PW-1:FB];

  always_ff @(posedge clk) begin
    if (adv) begin
      b <= (bq > (PW - FB)'(ONE)) ? ONE : bq[FB:0];
    end
  end

endmodule

### sv/mjp_lane.sv
module mjp_lane #(
  parameter int FB  = 16,
  parameter int DLY = 21
) (
  input  logic                               clk,
  input  logic                               adv,
  input  logic signed [mjp_pkg::POS_W-1:0]   start,
  input  logic signed [mjp_pkg::POS_W-1:0]   goal,
  input  logic [FB:0]                        b,
  output logic signed [mjp_pkg::POS_W-1:0]   pos
);

  localparam int PWD = mjp_pkg::POS_W;
  localparam int MW  = PWD + FB + 1;
  localparam logic [MW-1:0] HALF_M = MW'(1) << (FB - 1);

  logic [PWD:0]   dq;
  logic [PWD:0]   dq_abs;
  logic [PWD-1:0] mag_d   [DLY+1];
  logic           neg_d   [DLY+1];
  logic [PWD-1:0] start_d [DLY+1];
  logic [MW-1:0]  mprod_r;
  logic           neg_m;
  logic [PWD-1:0] start_m;
  logic [MW-1:0]  mprod_rnd;
  logic [PWD-1:0] delta;

  // exact 33-bit difference, magnitude always fits 32 bits
  assign dq     = {goal[PWD-1], goal} - {start[PWD-1], start};
  assign dq_abs = dq[PWD] ? -dq : dq;

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_d[0]   <= dq_abs[PWD-1:0];
      neg_d[0]   <= dq[PWD];
      start_d[0] <= start;
      for (int i = 1; i <= DLY; i++) begin
        mag_d[i]   <= mag_d[i-1];
        neg_d[i]   <= neg_d[i-1];
        start_d[i] <= start_d[i-1];
      end
      mprod_r <= MW'(mag_d[DLY]) * MW'(b);
      neg_m   <= neg_d[DLY];
      start_m <= start_d[DLY];
    end
  end

  // magnitude rounded, so halves go away from zero
  assign mprod_rnd = mprod_r + HALF_M;
  assign delta     = mprod_rnd[FB+PWD-1:FB];
  assign pos       = $signed(neg_m ? start_m - delta : start_m + delta);

endmodule
